// ===== hdl/lav_pkg.sv =====
// lav_pkg: shared widths for the look-at view matrix datapath
// used by lav_isqrt, lav_div and lav_norm; depends on nothing
`timescale 1ns / 1ps

package lav_pkg;

	// normalized magnitude width, leading one sits at bit NRM_W-1
	localparam int NRM_W  = 31;
	// sum of three squares of normalized magnitudes
	localparam int RAD_W  = 64;
	// floor square root of a RAD_W radicand
	localparam int ROOT_W = 32;

endpackage

// ===== hdl/lav_isqrt.sv =====
// lav_isqrt: pipelined integer square root, one result bit per stage
// depends on lav_pkg; carries an opaque sideband word along with each root
`timescale 1ns / 1ps

module lav_isqrt import lav_pkg::*; #(
	parameter int SW = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_vld,
	input  logic [RAD_W-1:0]  in_rad,
	input  logic [SW-1:0]     in_side,
	output logic              out_vld,
	output logic [ROOT_W-1:0] out_root,
	output logic [SW-1:0]     out_side
);

	logic [RAD_W-1:0] rad_d  [ROOT_W+1];
	logic [RAD_W-1:0] root_d [ROOT_W+1];
	logic [SW-1:0]    side_d [ROOT_W+1];
	logic             vld_d  [ROOT_W+1];

	logic [RAD_W-1:0] rad_s  [ROOT_W];
	logic [RAD_W-1:0] root_s [ROOT_W];
	logic [SW-1:0]    side_s [ROOT_W];
	logic             vld_s  [ROOT_W];

	assign rad_d[0]  = in_rad;
	assign root_d[0] = '0;
	assign side_d[0] = in_side;
	assign vld_d[0]  = in_vld;

	for (genvar i = 0; i < ROOT_W; i++) begin : g_step
		localparam logic [RAD_W-1:0] BIT = RAD_W'(1) << (RAD_W - 2 - 2 * i);
		logic [RAD_W-1:0] trial;
		logic             ge;

		assign trial = root_d[i] + BIT;
		assign ge    = rad_d[i] >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i] <= 1'b0;
			end else if (en) begin
				vld_s[i] <= vld_d[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rad_s[i]  <= ge ? rad_d[i] - trial : rad_d[i];
				root_s[i] <= ge ? (root_d[i] >> 1) + BIT : root_d[i] >> 1;
				side_s[i] <= side_d[i];
			end
		end

		assign rad_d[i+1]  = rad_s[i];
		assign root_d[i+1] = root_s[i];
		assign side_d[i+1] = side_s[i];
		assign vld_d[i+1]  = vld_s[i];
	end

	assign out_vld  = vld_d[ROOT_W];
	assign out_root = root_d[ROOT_W][ROOT_W-1:0];
	assign out_side = side_d[ROOT_W];

endmodule

// ===== hdl/lav_div.sv =====
// lav_div: three restoring dividers sharing one divisor, one quotient bit per stage
// depends on lav_pkg; quotient is round-to-nearest of num*2^FRAC_BITS / den
`timescale 1ns / 1ps

module lav_div import lav_pkg::*; #(
	parameter int SW        = 8,
	parameter int FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_vld,
	input  logic [NRM_W-1:0]   in_num [3],
	input  logic [ROOT_W-1:0]  in_den,
	input  logic [SW-1:0]      in_side,
	output logic               out_vld,
	output logic [FRAC_BITS:0] out_quo [3],
	output logic [SW-1:0]      out_side
);

	localparam int QW = FRAC_BITS + 1;
	localparam int RW = FRAC_BITS + ROOT_W + 1;

	logic [RW-1:0]     rem_d  [QW+1][3];
	logic [QW-1:0]     quo_d  [QW+1][3];
	logic [ROOT_W-1:0] den_d  [QW+1];
	logic [SW-1:0]     side_d [QW+1];
	logic              vld_d  [QW+1];

	logic [RW-1:0]     rem_s  [QW][3];
	logic [QW-1:0]     quo_s  [QW][3];
	logic [ROOT_W-1:0] den_s  [QW];
	logic [SW-1:0]     side_s [QW];
	logic              vld_s  [QW];

	// numerator gets half the divisor added so truncation rounds to nearest
	for (genvar l = 0; l < 3; l++) begin : g_init
		assign rem_d[0][l] = RW'({in_num[l], FRAC_BITS'(0)}) + RW'(in_den >> 1);
		assign quo_d[0][l] = '0;
	end
	assign den_d[0]  = in_den;
	assign side_d[0] = in_side;
	assign vld_d[0]  = in_vld;

	for (genvar j = 0; j < QW; j++) begin : g_step
		localparam int K = QW - 1 - j;
		logic [RW-1:0] dsh;

		assign dsh = RW'(den_d[j]) << K;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[j] <= 1'b0;
			end else if (en) begin
				vld_s[j] <= vld_d[j];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				den_s[j]  <= den_d[j];
				side_s[j] <= side_d[j];
			end
		end

		for (genvar l = 0; l < 3; l++) begin : g_lane
			logic ge;
			assign ge = rem_d[j][l] >= dsh;

			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[j][l] <= ge ? rem_d[j][l] - dsh : rem_d[j][l];
					quo_s[j][l] <= {quo_d[j][l][QW-2:0], ge};
				end
			end

			assign rem_d[j+1][l] = rem_s[j][l];
			assign quo_d[j+1][l] = quo_s[j][l];
		end

		assign den_d[j+1]  = den_s[j];
		assign side_d[j+1] = side_s[j];
		assign vld_d[j+1]  = vld_s[j];
	end

	for (genvar l = 0; l < 3; l++) begin : g_out
		assign out_quo[l] = quo_d[QW][l];
	end
	assign out_vld  = vld_d[QW];
	assign out_side = side_d[QW];

endmodule

// ===== hdl/lav_norm.sv =====
// lav_norm: pipelined unit vector of a 3-vector given as magnitudes and signs
// depends on lav_pkg, lav_isqrt and lav_div; zero vector gives zero result
`timescale 1ns / 1ps

module lav_norm import lav_pkg::*; #(
	parameter int MW        = 32,
	parameter int SW        = 8,
	parameter int FRAC_BITS = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic                       in_vld,
	input  logic [MW-1:0]              in_mag [3],
	input  logic [2:0]                 in_neg,
	input  logic [SW-1:0]              in_side,
	output logic                       out_vld,
	output logic signed [FRAC_BITS+1:0] out_unit [3],
	output logic [SW-1:0]              out_side
);

	localparam int PW  = $clog2(MW);
	localparam int XW  = MW + NRM_W - 1;
	localparam int QSW = SW + 4 + 3 * NRM_W;
	localparam int DSW = SW + 4;

	// s1: capture magnitudes
	logic [MW-1:0]      m_s1 [3];
	logic [2:0]         neg_s1;
	logic [SW-1:0]      side_s1;
	logic               vld_s1;
	// s2: leading one position of the largest magnitude
	logic [MW-1:0]      orv;
	logic [PW-1:0]      msb;
	logic [MW-1:0]      m_s2 [3];
	logic [PW-1:0]      msb_s2;
	logic               zero_s2;
	logic [2:0]         neg_s2;
	logic [SW-1:0]      side_s2;
	logic               vld_s2;
	// s3: shift so the leading one lands on bit NRM_W-1
	logic [XW-1:0]      wide [3];
	logic [NRM_W-1:0]   mn_s3 [3];
	logic               zero_s3;
	logic [2:0]         neg_s3;
	logic [SW-1:0]      side_s3;
	logic               vld_s3;
	// s4: squares
	logic [2*NRM_W-1:0] sq_s4 [3];
	logic [NRM_W-1:0]   mn_s4 [3];
	logic               zero_s4;
	logic [2:0]         neg_s4;
	logic [SW-1:0]      side_s4;
	logic               vld_s4;
	// s5: radicand
	logic [RAD_W-1:0]   rad_s5;
	logic [NRM_W-1:0]   mn_s5 [3];
	logic               zero_s5;
	logic [2:0]         neg_s5;
	logic [SW-1:0]      side_s5;
	logic               vld_s5;

	logic               sq_vld;
	logic [ROOT_W-1:0]  sq_root;
	logic [QSW-1:0]     sq_side;
	logic [NRM_W-1:0]   sq_mn [3];

	logic               dv_vld;
	logic [FRAC_BITS:0] dv_quo [3];
	logic [DSW-1:0]     dv_side;

	logic signed [FRAC_BITS+1:0] unit_s [3];
	logic [SW-1:0]      side_o;
	logic               vld_o;

	always_comb begin
		orv = m_s1[0] | m_s1[1] | m_s1[2];
		msb = '0;
		for (int b = 0; b < MW; b++) begin
			if (orv[b]) msb = PW'(b);
		end
	end

	always_comb begin
		for (int l = 0; l < 3; l++) begin
			wide[l] = {m_s2[l], (NRM_W-1)'(0)} >> msb_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_o  <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_o  <= dv_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_s1    <= in_mag;
			neg_s1  <= in_neg;
			side_s1 <= in_side;

			m_s2    <= m_s1;
			msb_s2  <= msb;
			zero_s2 <= orv == '0;
			neg_s2  <= neg_s1;
			side_s2 <= side_s1;

			for (int l = 0; l < 3; l++) mn_s3[l] <= wide[l][NRM_W-1:0];
			zero_s3 <= zero_s2;
			neg_s3  <= neg_s2;
			side_s3 <= side_s2;

			for (int l = 0; l < 3; l++) sq_s4[l] <= mn_s3[l] * mn_s3[l];
			mn_s4   <= mn_s3;
			zero_s4 <= zero_s3;
			neg_s4  <= neg_s3;
			side_s4 <= side_s3;

			rad_s5  <= RAD_W'(sq_s4[0]) + RAD_W'(sq_s4[1]) + RAD_W'(sq_s4[2]);
			mn_s5   <= mn_s4;
			zero_s5 <= zero_s4;
			neg_s5  <= neg_s4;
			side_s5 <= side_s4;
		end
	end

	lav_isqrt #(
		.SW(QSW)
	) u_isqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (vld_s5),
		.in_rad  (rad_s5),
		.in_side ({side_s5, neg_s5, zero_s5, mn_s5[0], mn_s5[1], mn_s5[2]}),
		.out_vld (sq_vld),
		.out_root(sq_root),
		.out_side(sq_side)
	);

	for (genvar l = 0; l < 3; l++) begin : g_mn
		assign sq_mn[l] = sq_side[(2-l)*NRM_W +: NRM_W];
	end

	lav_div #(
		.SW       (DSW),
		.FRAC_BITS(FRAC_BITS)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (sq_vld),
		.in_num  (sq_mn),
		.in_den  (sq_root),
		.in_side (sq_side[QSW-1 -: DSW]),
		.out_vld (dv_vld),
		.out_quo (dv_quo),
		.out_side(dv_side)
	);

	// sideband after the divider: {side, neg[2:0], zero}
	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < 3; l++) begin
				if (dv_side[0]) begin
					unit_s[l] <= '0;
				end else if (dv_side[1+l]) begin
					unit_s[l] <= -$signed({1'b0, dv_quo[l]});
				end else begin
					unit_s[l] <= $signed({1'b0, dv_quo[l]});
				end
			end
			side_o <= dv_side[DSW-1 -: SW];
		end
	end

	assign out_vld  = vld_o;
	assign out_unit = unit_s;
	assign out_side = side_o;

endmodule

// ===== hdl/look_at_view_matrix.sv =====
// look_at_view_matrix: camera view matrix rows from position, look and up vectors
// one word enters per cycle, sustained throughput one word per cycle, while no output word waits
// the whole pipeline advances together; it holds only while the output word waits
// arst_n clears all valid bits; data registers are not reset
// depends on lav_pkg, lav_norm (with lav_isqrt and lav_div)
`timescale 1ns / 1ps

module look_at_view_matrix import lav_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic signed [31:0] pos_z,
	input  logic signed [31:0] look_x,
	input  logic signed [31:0] look_y,
	input  logic signed [31:0] look_z,
	input  logic signed [31:0] up_x,
	input  logic signed [31:0] up_y,
	input  logic signed [31:0] up_z,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [17:0] right_x,
	output logic signed [17:0] right_y,
	output logic signed [17:0] right_z,
	output logic signed [17:0] upward_x,
	output logic signed [17:0] upward_y,
	output logic signed [17:0] upward_z,
	output logic signed [17:0] back_x,
	output logic signed [17:0] back_y,
	output logic signed [17:0] back_z,
	output logic signed [31:0] shift_x,
	output logic signed [31:0] shift_y,
	output logic signed [31:0] shift_z
);

	localparam int WW  = FRAC_BITS + 2;
	localparam int UW  = 34;
	localparam int TW  = 35;
	localparam int S1W = 192;
	localparam int S2W = 3 * WW + 96;
	localparam logic signed [63:0] ONE  = 64'sd1 <<< FRAC_BITS;
	localparam logic signed [63:0] SMAX = 64'sd2147483647;
	localparam logic signed [63:0] SMIN = -64'sd2147483648;

	function automatic logic signed [63:0] rnd(input logic signed [63:0] v);
		logic [63:0] m;
		logic [63:0] r;
		m = v[63] ? 64'(-v) : 64'(v);
		r = (m + (64'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
		return v[63] ? -$signed(r) : $signed(r);
	endfunction

	function automatic logic signed [63:0] clampu(input logic signed [63:0] v);
		if (v > ONE) return ONE;
		if (v < -ONE) return -ONE;
		return v;
	endfunction

	function automatic logic signed [31:0] nsat(input logic signed [63:0] v);
		logic signed [63:0] d;
		d = -rnd(v);
		if (d > SMAX) d = SMAX;
		if (d < SMIN) d = SMIN;
		return 32'(d);
	endfunction

	logic en;

	logic signed [31:0] look_v [3];
	logic [31:0]        look_m [3];
	logic [2:0]         look_n;

	logic               n1_vld;
	logic signed [WW-1:0] w_n1 [3];
	logic [S1W-1:0]     side_n1;
	logic signed [31:0] pos_n1 [3];
	logic signed [31:0] up_n1  [3];

	logic signed [31+WW:0] pd_s1 [3];
	logic signed [WW-1:0]  w_s1  [3];
	logic signed [31:0]    pos_s1 [3];
	logic signed [31:0]    up_s1  [3];
	logic signed [33+WW:0] dsum_s2;
	logic signed [WW-1:0]  w_s2  [3];
	logic signed [31:0]    pos_s2 [3];
	logic signed [31:0]    up_s2  [3];
	logic signed [UW-1:0]  upw_s3;
	logic signed [WW-1:0]  w_s3  [3];
	logic signed [31:0]    pos_s3 [3];
	logic signed [31:0]    up_s3  [3];
	logic signed [UW+WW-1:0] pu_s4 [3];
	logic signed [WW-1:0]  w_s4  [3];
	logic signed [31:0]    pos_s4 [3];
	logic signed [31:0]    up_s4  [3];
	logic signed [TW-1:0]  t_s5  [3];
	logic signed [WW-1:0]  w_s5  [3];
	logic signed [31:0]    pos_s5 [3];
	logic                  vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;

	logic [TW-1:0]         t_m [3];
	logic [2:0]            t_n;

	logic                  n2_vld;
	logic signed [WW-1:0]  v_n2 [3];
	logic [S2W-1:0]        side_n2;
	logic signed [WW-1:0]  w_n2 [3];
	logic signed [31:0]    pos_n2 [3];

	logic signed [2*WW-1:0] xp_s6 [6];
	logic signed [WW-1:0]  v_s6 [3];
	logic signed [WW-1:0]  w_s6 [3];
	logic signed [31:0]    pos_s6 [3];
	logic signed [WW-1:0]  u_s7 [3];
	logic signed [WW-1:0]  v_s7 [3];
	logic signed [WW-1:0]  w_s7 [3];
	logic signed [31:0]    pos_s7 [3];
	logic signed [31+WW:0] hp_s8 [3][3];
	logic signed [WW-1:0]  ax_s8 [3][3];
	logic signed [33+WW:0] hs_s9 [3];
	logic signed [WW-1:0]  ax_s9 [3][3];
	logic signed [31:0]    sh_s10 [3];
	logic signed [WW-1:0]  ax_s10 [3][3];
	logic                  vld_s6, vld_s7, vld_s8, vld_s9, vld_s10;

	assign en       = !vld_s10 || out_ready;
	assign in_ready = en;

	// back axis is the negated unit look, so the sign goes in flipped
	assign look_v[0] = look_x;
	assign look_v[1] = look_y;
	assign look_v[2] = look_z;
	for (genvar l = 0; l < 3; l++) begin : g_look
		assign look_m[l] = look_v[l][31] ? 32'(-look_v[l]) : 32'(look_v[l]);
		assign look_n[l] = !look_v[l][31] && (look_v[l] != '0);
	end

	lav_norm #(
		.MW       (32),
		.SW       (S1W),
		.FRAC_BITS(FRAC_BITS)
	) u_norm_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (in_valid),
		.in_mag  (look_m),
		.in_neg  (look_n),
		.in_side ({pos_x, pos_y, pos_z, up_x, up_y, up_z}),
		.out_vld (n1_vld),
		.out_unit(w_n1),
		.out_side(side_n1)
	);

	for (genvar l = 0; l < 3; l++) begin : g_side1
		assign pos_n1[l] = $signed(side_n1[96 + (2-l)*32 +: 32]);
		assign up_n1[l]  = $signed(side_n1[(2-l)*32 +: 32]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			vld_s3  <= 1'b0;
			vld_s4  <= 1'b0;
			vld_s5  <= 1'b0;
			vld_s6  <= 1'b0;
			vld_s7  <= 1'b0;
			vld_s8  <= 1'b0;
			vld_s9  <= 1'b0;
			vld_s10 <= 1'b0;
		end else if (en) begin
			vld_s1  <= n1_vld;
			vld_s2  <= vld_s1;
			vld_s3  <= vld_s2;
			vld_s4  <= vld_s3;
			vld_s5  <= vld_s4;
			vld_s6  <= n2_vld;
			vld_s7  <= vld_s6;
			vld_s8  <= vld_s7;
			vld_s9  <= vld_s8;
			vld_s10 <= vld_s9;
		end
	end

	// projection of up onto back, then the residual
	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < 3; l++) pd_s1[l] <= up_n1[l] * w_n1[l];
			w_s1   <= w_n1;
			pos_s1 <= pos_n1;
			up_s1  <= up_n1;

			dsum_s2 <= (34+WW)'(pd_s1[0]) + (34+WW)'(pd_s1[1]) + (34+WW)'(pd_s1[2]);
			w_s2    <= w_s1;
			pos_s2  <= pos_s1;
			up_s2   <= up_s1;

			upw_s3 <= UW'(rnd(64'(dsum_s2)));
			w_s3   <= w_s2;
			pos_s3 <= pos_s2;
			up_s3  <= up_s2;

			for (int l = 0; l < 3; l++) pu_s4[l] <= upw_s3 * w_s3[l];
			w_s4   <= w_s3;
			pos_s4 <= pos_s3;
			up_s4  <= up_s3;

			for (int l = 0; l < 3; l++) t_s5[l] <= TW'(64'(up_s4[l]) - rnd(64'(pu_s4[l])));
			w_s5   <= w_s4;
			pos_s5 <= pos_s4;
		end
	end

	for (genvar l = 0; l < 3; l++) begin : g_t
		assign t_m[l] = t_s5[l][TW-1] ? TW'(-t_s5[l]) : TW'(t_s5[l]);
		assign t_n[l] = t_s5[l][TW-1];
	end

	lav_norm #(
		.MW       (TW),
		.SW       (S2W),
		.FRAC_BITS(FRAC_BITS)
	) u_norm_up (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (vld_s5),
		.in_mag  (t_m),
		.in_neg  (t_n),
		.in_side ({w_s5[0], w_s5[1], w_s5[2], pos_s5[0], pos_s5[1], pos_s5[2]}),
		.out_vld (n2_vld),
		.out_unit(v_n2),
		.out_side(side_n2)
	);

	for (genvar l = 0; l < 3; l++) begin : g_side2
		assign w_n2[l]   = $signed(side_n2[96 + (2-l)*WW +: WW]);
		assign pos_n2[l] = $signed(side_n2[(2-l)*32 +: 32]);
	end

	// right = upward x back, then the three negated dot products
	always_ff @(posedge clk) begin
		if (en) begin
			xp_s6[0] <= v_n2[1] * w_n2[2];
			xp_s6[1] <= v_n2[2] * w_n2[1];
			xp_s6[2] <= v_n2[2] * w_n2[0];
			xp_s6[3] <= v_n2[0] * w_n2[2];
			xp_s6[4] <= v_n2[0] * w_n2[1];
			xp_s6[5] <= v_n2[1] * w_n2[0];
			v_s6   <= v_n2;
			w_s6   <= w_n2;
			pos_s6 <= pos_n2;

			for (int l = 0; l < 3; l++) begin
				u_s7[l] <= WW'(clampu(rnd(64'(xp_s6[2*l]) - 64'(xp_s6[2*l+1]))));
			end
			v_s7   <= v_s6;
			w_s7   <= w_s6;
			pos_s7 <= pos_s6;

			for (int l = 0; l < 3; l++) begin
				hp_s8[0][l] <= u_s7[l] * pos_s7[l];
				hp_s8[1][l] <= v_s7[l] * pos_s7[l];
				hp_s8[2][l] <= w_s7[l] * pos_s7[l];
			end
			ax_s8[0] <= u_s7;
			ax_s8[1] <= v_s7;
			ax_s8[2] <= w_s7;

			for (int r = 0; r < 3; r++) begin
				hs_s9[r] <= (34+WW)'(hp_s8[r][0]) + (34+WW)'(hp_s8[r][1])
					+ (34+WW)'(hp_s8[r][2]);
			end
			ax_s9 <= ax_s8;

			for (int r = 0; r < 3; r++) sh_s10[r] <= nsat(64'(hs_s9[r]));
			ax_s10 <= ax_s9;
		end
	end

	assign out_valid = vld_s10;
	assign right_x   = 18'(ax_s10[0][0]);
	assign right_y   = 18'(ax_s10[0][1]);
	assign right_z   = 18'(ax_s10[0][2]);
	assign upward_x  = 18'(ax_s10[1][0]);
	assign upward_y  = 18'(ax_s10[1][1]);
	assign upward_z  = 18'(ax_s10[1][2]);
	assign back_x    = 18'(ax_s10[2][0]);
	assign back_y    = 18'(ax_s10[2][1]);
	assign back_z    = 18'(ax_s10[2][2]);
	assign shift_x   = sh_s10[0];
	assign shift_y   = sh_s10[1];
	assign shift_z   = sh_s10[2];

endmodule
